@@ sv/olad_pkg.sv @@
package olad_pkg;

  // Store size and the widths that follow from it.
  localparam int CAPACITY = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int POS_W    = 6;
  localparam int FUNC_W   = 2;
  localparam int STAT_W   = 2;

  // Operation codes carried on the input tuser.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_REPORT = 2'd2
  } func_t;

  // Status codes carried on the output tuser.
  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_NOTFOUND = 2'd2,
    STAT_EMPTY    = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic             shift;
    logic [IDX_W-1:0] tail_idx;
    logic             wr;
    logic [IDX_W-1:0] wr_idx;
  } cell_ctrl_t;

endpackage

@@ sv/olad_cell.sv @@
module olad_cell (
  input  logic                       clk,
  input  logic [olad_pkg::IDX_W-1:0] idx,
  input  olad_pkg::cell_ctrl_t       ctrl,
  input  logic [olad_pkg::VAL_W-1:0] next_in,
  input  logic [olad_pkg::VAL_W-1:0] head_in,
  input  logic [olad_pkg::VAL_W-1:0] wr_value,
  output logic [olad_pkg::VAL_W-1:0] data
);

  logic [olad_pkg::VAL_W-1:0] data_r;
  logic [olad_pkg::VAL_W-1:0] data_nxt;

  // A shift moves the list one place toward the head; the tail cell takes
  // the old head so the list rotates as a ring. An append writes one cell.
  always_comb begin
    data_nxt = data_r;
    if (ctrl.shift) begin
      data_nxt = (idx == ctrl.tail_idx) ? head_in : next_in;
    end else if (ctrl.wr && (idx == ctrl.wr_idx)) begin
      data_nxt = wr_value;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

@@ sv/ordered_list_append_delete_unit.sv @@
// Append and the single-result cases give a registered result in the cycle after accept.
// Delete and report rotate the list once through a chain of cells, one entry per cycle
// while the output is not stalled; results of a report leave one per cycle behind the head cell.
// A new item is taken only once the previous one has finished its rotation.
// Reset (rst_n low, synchronous) empties the list and drops any pending result;
// cell contents are not cleared.
module ordered_list_append_delete_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [1:0]  in_tuser,   // [1:0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] entry_value, [37:32] position, [39:38] zero
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast   // last
);

  localparam int CAP   = olad_pkg::CAPACITY;
  localparam int IDX_W = olad_pkg::IDX_W;
  localparam int CNT_W = olad_pkg::CNT_W;
  localparam int VAL_W = olad_pkg::VAL_W;
  localparam int POS_W = olad_pkg::POS_W;

  // Sequencer and list bookkeeping.
  olad_pkg::state_t  state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  len_r, len_nxt;
  logic [IDX_W-1:0]  step_r, step_nxt;
  logic              found_r, found_nxt;
  logic [IDX_W-1:0]  fpos_r, fpos_nxt;
  logic              is_del_r, is_del_nxt;
  logic [VAL_W-1:0]  key_r, key_nxt;

  // Output register.
  logic                      out_valid_r, out_valid_nxt;
  olad_pkg::status_t         out_status_r, out_status_nxt;
  logic [VAL_W-1:0]          out_value_r, out_value_nxt;
  logic [POS_W-1:0]          out_pos_r, out_pos_nxt;
  logic                      out_last_r, out_last_nxt;

  olad_pkg::cell_ctrl_t      ctrl;
  logic [VAL_W-1:0]          cell_data [CAP];
  logic [VAL_W-1:0]          head;
  olad_pkg::func_t           in_func;
  logic                      out_free;
  logic                      in_acc;
  logic                      final_step;
  logic                      match;
  logic [CNT_W-1:0]          len_m1;

  assign head       = cell_data[0];
  assign in_func    = olad_pkg::func_t'(in_tuser);
  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == olad_pkg::ST_IDLE) && out_free;
  assign in_acc     = in_tvalid && in_tready;
  assign len_m1     = len_r - CNT_W'(1);
  assign final_step = ({1'b0, step_r} == CNT_W'(count_r - CNT_W'(1)));
  assign match      = is_del_r && !found_r && (head == key_r);

  // Chain of cells, each handing its entry to the one nearer the head.
  for (genvar g = 0; g < CAP; g++) begin : g_cell
    logic [VAL_W-1:0] nbr;
    if (g == CAP - 1) begin : g_end
      assign nbr = head;
    end else begin : g_mid
      assign nbr = cell_data[g+1];
    end
    olad_cell u_cell (
      .clk      (clk),
      .idx      (IDX_W'(g)),
      .ctrl     (ctrl),
      .next_in  (nbr),
      .head_in  (head),
      .wr_value (in_tdata),
      .data     (cell_data[g])
    );
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      olad_pkg::ST_IDLE: begin
        if (in_acc && (count_r != '0) &&
            ((in_func == olad_pkg::FUNC_DELETE) || (in_func == olad_pkg::FUNC_REPORT))) begin
          state_nxt = olad_pkg::ST_RUN;
        end
      end
      olad_pkg::ST_RUN: begin
        if (out_free && final_step) begin
          state_nxt = olad_pkg::ST_IDLE;
        end
      end
      default: state_nxt = olad_pkg::ST_IDLE;
    endcase
  end

  // Datapath control and result formation.
  always_comb begin
    count_nxt      = count_r;
    len_nxt        = len_r;
    step_nxt       = step_r;
    found_nxt      = found_r;
    fpos_nxt       = fpos_r;
    is_del_nxt     = is_del_r;
    key_nxt        = key_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_pos_nxt    = out_pos_r;
    out_last_nxt   = out_last_r;
    ctrl.shift     = 1'b0;
    ctrl.tail_idx  = len_m1[IDX_W-1:0];
    ctrl.wr        = 1'b0;
    ctrl.wr_idx    = count_r[IDX_W-1:0];

    unique case (state_r)
      olad_pkg::ST_IDLE: begin
        if (in_acc) begin
          // Default single result; the cases below refine it.
          out_valid_nxt  = 1'b1;
          out_status_nxt = olad_pkg::STAT_OK;
          out_value_nxt  = '0;
          out_pos_nxt    = '0;
          out_last_nxt   = 1'b1;
          step_nxt       = '0;
          len_nxt        = count_r;
          found_nxt      = 1'b0;
          key_nxt        = in_tdata;
          is_del_nxt     = (in_func == olad_pkg::FUNC_DELETE);
          if (in_func == olad_pkg::FUNC_APPEND) begin
            if (count_r == CNT_W'(CAP)) begin
              out_status_nxt = olad_pkg::STAT_FULL;
            end else begin
              ctrl.wr     = 1'b1;
              out_pos_nxt = POS_W'(count_r);
              count_nxt   = count_r + CNT_W'(1);
            end
          end else if ((in_func == olad_pkg::FUNC_DELETE) ||
                       (in_func == olad_pkg::FUNC_REPORT)) begin
            if (count_r == '0) begin
              out_status_nxt = olad_pkg::STAT_EMPTY;
            end else begin
              // The rotation produces the results.
              out_valid_nxt = 1'b0;
            end
          end
        end
      end
      olad_pkg::ST_RUN: begin
        if (out_free) begin
          // Pop the head and push it back at the tail, unless it is the deleted one.
          ctrl.shift = 1'b1;
          step_nxt   = step_r + IDX_W'(1);
          if (match) begin
            found_nxt = 1'b1;
            fpos_nxt  = step_r;
            len_nxt   = len_m1;
          end
          if (!is_del_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = olad_pkg::STAT_OK;
            out_value_nxt  = head;
            out_pos_nxt    = POS_W'(step_r);
            out_last_nxt   = final_step;
          end else if (final_step) begin
            out_valid_nxt = 1'b1;
            out_value_nxt = '0;
            out_last_nxt  = 1'b1;
            if (match || found_r) begin
              out_status_nxt = olad_pkg::STAT_OK;
              out_pos_nxt    = POS_W'(match ? step_r : fpos_r);
              count_nxt      = count_r - CNT_W'(1);
            end else begin
              out_status_nxt = olad_pkg::STAT_NOTFOUND;
              out_pos_nxt    = '0;
            end
          end
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= olad_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    len_r        <= len_nxt;
    step_r       <= step_nxt;
    found_r      <= found_nxt;
    fpos_r       <= fpos_nxt;
    is_del_r     <= is_del_nxt;
    key_r        <= key_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_pos_r    <= out_pos_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_pos_r, out_value_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule
